### sv/temon_pkg.sv
// Package for the task execution time monitor: operation codes, controller states,
// slot record layouts and the fixed field widths of the stream beats.
// No dependencies.
`default_nettype none

package temon_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned OP_W   = 3;

	// Input beat: slot, now_us, period packed from bit 0, padded to whole bytes.
	localparam int unsigned IN_DATA_W  = 72;
	// Output beat: slot_index, then six 32-bit figures, padded to whole bytes.
	localparam int unsigned OUT_DATA_W = 200;

	localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_REGISTER  = 3'd0,
		OP_BEGIN     = 3'd1,
		OP_END       = 3'd2,
		OP_RESET_ALL = 3'd3,
		OP_READ      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESP,
		ST_DIFF,
		ST_UPD,
		ST_CLEAR
	} state_t;

	// Per-slot timing entry: written whole at registration, start field alone on begin.
	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] start;
	} stamp_t;

	// Per-slot statistics entry.
	typedef struct packed {
		logic [TIME_W-1:0] misses;
		logic [TIME_W-1:0] samples;
		logic [TIME_W-1:0] sum;
		logic [TIME_W-1:0] greatest;
		logic [TIME_W-1:0] least;
	} stat_t;

	localparam stat_t STAT_CLEAR = '{
		misses:   '0,
		samples:  '0,
		sum:      '0,
		greatest: '0,
		least:    ALL_ONES
	};

endpackage : temon_pkg

`default_nettype wire

### sv/task_execution_time_monitor_core.sv
// Task execution time monitor: slot table held in two synchronous memories,
// sequenced by a small controller. Depends on temon_pkg.
//
//  Channel   Direction  tdata (low bit up)                          tuser
//  s_axis    in         slot, now_us, period, zero pad              operation
//  m_axis    out        slot_index, min_time, max_time, time_sum,   ok
//                       samples, misses, slot_period, zero pad
//
// Begin completes on acceptance; register and read pass through the response state;
// end passes through the memory read, then the elapsed-time difference register, then
// the statistics write-back. Reset all sweeps the registered slots: the sweep writes
// one statistics entry per cycle through the single write port.
// Reset clears only the control state; every memory entry is written at registration
// before it can be read, so no clearing pass follows reset.
// A result waiting on m_axis holds the controller in its response state; begin,
// end and reset-all beats are taken while an earlier result still waits.
`default_nettype none

module task_execution_time_monitor_core
	import temon_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot[3:0], now_us[35:4], period[67:36]
	input  wire logic [OP_W-1:0]       s_axis_tuser,  // operation[2:0]

	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [OUT_DATA_W-1:0] m_axis_tdata,  // slot_index[3:0], min_time[35:4],
	                                                  // max_time[67:36], time_sum[99:68],
	                                                  // samples[131:100], misses[163:132],
	                                                  // slot_period[195:164]
	output      logic                  m_axis_tuser   // ok[0]
);

	localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned UW = $clog2(SLOT_COUNT + 1);
	localparam int unsigned LW = UW + SLOT_W;

	// Input beat fields.
	logic [SLOT_W-1:0] in_slot;
	logic [TIME_W-1:0] in_now;
	logic [TIME_W-1:0] in_period;
	op_t               in_op;

	assign in_slot   = s_axis_tdata[SLOT_W-1:0];
	assign in_now    = s_axis_tdata[SLOT_W+TIME_W-1:SLOT_W];
	assign in_period = s_axis_tdata[SLOT_W+2*TIME_W-1:SLOT_W+TIME_W];
	assign in_op     = op_t'(s_axis_tuser);

	// Control state.
	state_t          state_q, state_d;
	logic [UW-1:0]   used_q;
	logic [AW-1:0]   ptr_q;
	logic            out_valid_q;

	// Payload registers.
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] period_q;
	op_t               op_q;
	logic [SLOT_W-1:0] resp_slot_q;
	logic              resp_ok_q;
	logic [TIME_W-1:0] t_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic              out_ok_q;

	// Memories and their registered read ports.
	stamp_t stamp_mem [SLOT_COUNT];
	stat_t  stat_mem  [SLOT_COUNT];
	stamp_t stamp_rd_q;
	stat_t  stat_rd_q;

	logic            s_accept;
	logic            full;
	logic            live_in;
	logic            out_free;
	logic            load_out;
	logic            sweep_last;
	logic            used_inc;
	logic            stamp_reg_we;
	logic            stamp_begin_we;
	logic            stat_we;
	logic [AW-1:0]   stat_waddr;
	stat_t           stat_wdata;
	stat_t           stat_upd;
	logic [OUT_DATA_W-1:0] out_data_d;

	assign s_accept   = s_axis_tvalid && s_axis_tready;
	assign full       = (used_q == UW'(SLOT_COUNT));
	assign live_in    = (LW'(in_slot) < LW'(used_q));
	assign out_free   = !out_valid_q || m_axis_tready;
	assign sweep_last = ((UW'(ptr_q) + UW'(1)) == used_q);

	// Statistics update for a completed execution.
	always_comb begin
		stat_upd          = stat_rd_q;
		stat_upd.least    = (t_q < stat_rd_q.least) ? t_q : stat_rd_q.least;
		stat_upd.greatest = (t_q > stat_rd_q.greatest) ? t_q : stat_rd_q.greatest;
		stat_upd.sum      = stat_rd_q.sum + t_q;
		stat_upd.samples  = stat_rd_q.samples + TIME_W'(1);
		stat_upd.misses   = stat_rd_q.misses
			+ TIME_W'((stamp_rd_q.period != '0) && (t_q > stamp_rd_q.period));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					unique case (in_op)
						OP_REGISTER:  state_d = ST_RESP;
						OP_READ:      state_d = ST_RESP;
						OP_END:       state_d = live_in ? ST_DIFF : ST_IDLE;
						OP_RESET_ALL: state_d = (used_q != '0) ? ST_CLEAR : ST_IDLE;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_RESP:  if (out_free) state_d = ST_IDLE;
			ST_DIFF:  state_d = ST_UPD;
			ST_UPD:   state_d = ST_IDLE;
			ST_CLEAR: if (sweep_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Controller outputs: handshake, memory write ports, result load.
	always_comb begin
		s_axis_tready  = (state_q == ST_IDLE);
		load_out       = (state_q == ST_RESP) && out_free;
		used_inc       = 1'b0;
		stamp_reg_we   = 1'b0;
		stamp_begin_we = 1'b0;
		stat_we        = 1'b0;
		stat_waddr     = AW'(used_q);
		stat_wdata     = STAT_CLEAR;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && (in_op == OP_REGISTER) && !full) begin
					used_inc     = 1'b1;
					stamp_reg_we = 1'b1;
					stat_we      = 1'b1;
				end
				if (s_accept && (in_op == OP_BEGIN) && live_in) begin
					stamp_begin_we = 1'b1;
				end
			end
			ST_UPD: begin
				stat_we    = 1'b1;
				stat_waddr = AW'(slot_q);
				stat_wdata = stat_upd;
			end
			ST_CLEAR: begin
				stat_we    = 1'b1;
				stat_waddr = ptr_q;
			end
			default: begin
			end
		endcase
	end

	// Result assembly: failures carry only the slot index.
	always_comb begin
		out_data_d = OUT_DATA_W'(resp_slot_q);
		if (resp_ok_q) begin
			if (op_q == OP_REGISTER) begin
				out_data_d = OUT_DATA_W'({period_q, STAT_CLEAR, resp_slot_q});
			end else begin
				out_data_d = OUT_DATA_W'({stamp_rd_q.period, stat_rd_q, resp_slot_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_inc) begin
				used_q <= used_q + UW'(1);
			end
			if (state_q == ST_CLEAR) begin
				ptr_q <= ptr_q + AW'(1);
			end else begin
				ptr_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			slot_q   <= in_slot;
			now_q    <= in_now;
			period_q <= in_period;
			op_q     <= in_op;
			if (in_op == OP_REGISTER) begin
				resp_slot_q <= full ? '0 : SLOT_W'(used_q);
				resp_ok_q   <= !full;
			end else begin
				resp_slot_q <= in_slot;
				resp_ok_q   <= live_in;
			end
		end
		if (state_q == ST_DIFF) begin
			t_q <= now_q - stamp_rd_q.start;
		end
		if (load_out) begin
			out_data_q <= out_data_d;
			out_ok_q   <= resp_ok_q;
		end
	end

	// The stamp memory has no reset, so registration writes a slot's start stamp as zero;
	// begin is ignored on unregistered slots, so nothing else writes it before then.
	always_ff @(posedge clk) begin
		if (stamp_reg_we) begin
			stamp_mem[AW'(used_q)] <= '{period: in_period, start: '0};
		end else if (stamp_begin_we) begin
			stamp_mem[AW'(in_slot)].start <= in_now;
		end
		if (s_accept) begin
			stamp_rd_q <= stamp_mem[AW'(in_slot)];
		end
	end

	always_ff @(posedge clk) begin
		if (stat_we) begin
			stat_mem[stat_waddr] <= stat_wdata;
		end
		if (s_accept) begin
			stat_rd_q <= stat_mem[AW'(in_slot)];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ok_q;

	// The slot table never grows beyond its size.
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(used_q) <= LW'(SLOT_COUNT))
		else $error("slot count exceeds table size");

	// Registration claims exactly one slot at a time.
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + UW'(1)))
		else $error("slot count moved by more than one");

	// The clearing sweep stays within the registered slots.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (UW'(ptr_q) < used_q))
		else $error("clearing sweep beyond registered slots");

	// A result is only loaded while the previous one has left or is leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || m_axis_tready))
		else $error("pending result overwritten");

endmodule : task_execution_time_monitor_core

`default_nettype wire

### dv/temon_stats_checker.sv
// Checker for the task execution time monitor: it watches both stream channels, keeps its own
// copy of the slot table and compares every result beat with the oldest predicted report.
// Depends on temon_pkg.
module temon_stats_checker
	import temon_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot, now_us, period
	input  wire logic [OP_W-1:0]       s_axis_tuser,  // operation
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,  // slot_index, min, max, sum, samples,
	                                                  // misses, slot_period
	input  wire logic                  m_axis_tuser,  // ok
	output int unsigned                error_count,
	output int unsigned                reports_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = 1 << SLOT_W;

	typedef struct {
		logic [SLOT_W-1:0] slot_index;
		logic              ok;
		logic [TIME_W-1:0] min_time;
		logic [TIME_W-1:0] max_time;
		logic [TIME_W-1:0] time_sum;
		logic [TIME_W-1:0] samples;
		logic [TIME_W-1:0] misses;
		logic [TIME_W-1:0] slot_period;
	} report_t;

	logic [TIME_W-1:0] stamp_q    [SLOTS];
	logic [TIME_W-1:0] least_q    [SLOTS];
	logic [TIME_W-1:0] greatest_q [SLOTS];
	logic [TIME_W-1:0] sum_q      [SLOTS];
	logic [TIME_W-1:0] count_q    [SLOTS];
	logic [TIME_W-1:0] miss_q     [SLOTS];
	logic [TIME_W-1:0] period_q   [SLOTS];
	int unsigned       slots_taken;
	report_t           expected_reports [$];
	report_t           oldest;

	task automatic clear_stats(int unsigned idx);
		least_q[idx]    = ALL_ONES;
		greatest_q[idx] = '0;
		sum_q[idx]      = '0;
		count_q[idx]    = '0;
		miss_q[idx]     = '0;
	endtask

	function automatic report_t slot_report(logic [SLOT_W-1:0] idx, bit good);
		report_t r;
		r = '{default: '0};
		r.slot_index = idx;
		if (good) begin
			r.ok          = 1'b1;
			r.min_time    = least_q[idx];
			r.max_time    = greatest_q[idx];
			r.time_sum    = sum_q[idx];
			r.samples     = count_q[idx];
			r.misses      = miss_q[idx];
			r.slot_period = period_q[idx];
		end
		return r;
	endfunction

	// Advances the predicted slot table by one accepted input beat.
	task automatic track_event(op_t op, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] period);
		logic [TIME_W-1:0] elapsed;
		bit                live;
		live = slot < slots_taken;
		case (op)
			OP_REGISTER: begin
				if (slots_taken >= SLOTS) begin
					expected_reports.push_back(slot_report('0, 1'b0));
				end else begin
					period_q[slots_taken] = period;
					clear_stats(slots_taken);
					slots_taken++;
					expected_reports.push_back(slot_report(SLOT_W'(slots_taken - 1), 1'b1));
				end
			end
			OP_BEGIN: begin
				if (live)
					stamp_q[slot] = now;
			end
			OP_END: begin
				if (live) begin
					elapsed = now - stamp_q[slot];
					if (elapsed < least_q[slot])
						least_q[slot] = elapsed;
					if (elapsed > greatest_q[slot])
						greatest_q[slot] = elapsed;
					sum_q[slot]   = sum_q[slot] + elapsed;
					count_q[slot] = count_q[slot] + TIME_W'(1);
					// A zero period marks an event-driven task with no deadline.
					if (period_q[slot] != '0 && elapsed > period_q[slot])
						miss_q[slot] = miss_q[slot] + TIME_W'(1);
				end
			end
			OP_RESET_ALL: begin
				for (int unsigned i = 0; i < slots_taken; i++)
					clear_stats(i);
			end
			OP_READ: begin
				expected_reports.push_back(slot_report(slot, live));
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned i = 0; i < SLOTS; i++) begin
				stamp_q[i]  = '0;
				period_q[i] = '0;
				clear_stats(i);
			end
			slots_taken = 0;
			expected_reports.delete();
			reports_due = 0;
			error_count = 0;
		end else begin
			// The input beat is queued first so that a result in the same cycle still finds
			// its own expectation at the front.
			if (s_axis_tvalid && s_axis_tready)
				track_event(op_t'(s_axis_tuser), s_axis_tdata[0 +: SLOT_W],
					s_axis_tdata[SLOT_W +: TIME_W], s_axis_tdata[SLOT_W + TIME_W +: TIME_W]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					error_count++;
					$display("%0t ns: result beat with none expected, slot_index %0h, ok %0b",
						$time, m_axis_tdata[0 +: SLOT_W], m_axis_tuser);
				end else begin
					oldest = expected_reports.pop_front();
					check_field("slot_index", TIME_W'(oldest.slot_index),
						TIME_W'(m_axis_tdata[0 +: SLOT_W]));
					check_field("ok", TIME_W'(oldest.ok), TIME_W'(m_axis_tuser));
					check_field("min_time", oldest.min_time, m_axis_tdata[SLOT_W +: TIME_W]);
					check_field("max_time", oldest.max_time,
						m_axis_tdata[SLOT_W + TIME_W +: TIME_W]);
					check_field("time_sum", oldest.time_sum,
						m_axis_tdata[SLOT_W + 2 * TIME_W +: TIME_W]);
					check_field("samples", oldest.samples,
						m_axis_tdata[SLOT_W + 3 * TIME_W +: TIME_W]);
					check_field("misses", oldest.misses,
						m_axis_tdata[SLOT_W + 4 * TIME_W +: TIME_W]);
					check_field("slot_period", oldest.slot_period,
						m_axis_tdata[SLOT_W + 5 * TIME_W +: TIME_W]);
				end
			end
			reports_due = expected_reports.size();
		end
	end

endmodule : temon_stats_checker

### dv/tb_task_execution_time_monitor_core.sv
// Top of the task execution time monitor testbench: clock, reset, beat stimulus with random
// gaps and back-pressure, watchdog and verdict. Depends on temon_pkg, the core and
// temon_stats_checker.
module tb_task_execution_time_monitor_core;
	timeunit 1ns;
	timeprecision 1ps;

	import temon_pkg::*;

	localparam int unsigned HALF_PERIOD     = 6;
	localparam int unsigned RESET_CYCLES    = 7;
	localparam int unsigned SLOTS           = 1 << SLOT_W;
	localparam int unsigned RANDOM_ITEMS    = 400;
	localparam int unsigned IDLE_LIMIT      = 4000;
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned HOLD_OFF_AT     = 150;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam logic [OP_W-1:0] OP_FIRST_SPARE = OP_READ + 1'b1;
	localparam logic [OP_W-1:0] OP_LAST_SPARE  = '1;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // slot, now_us, period, zero pad
	logic [OP_W-1:0]       s_axis_tuser  = '0;  // operation
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // slot_index, min, max, sum, samples, misses,
	                                            // slot_period, zero pad
	logic                  m_axis_tuser;        // ok

	int unsigned error_count;
	int unsigned reports_due;

	// Stimulus-side view of the table, used to pick slots, fill the table and shape begin and end pairs.
	int unsigned       registered  = 0;
	int unsigned       beats_sent  = 0;
	int unsigned       idle_cycles = 0;
	logic [TIME_W-1:0] begun_at    [SLOTS] = '{default: '0};
	logic [TIME_W-1:0] task_period [SLOTS] = '{default: '0};

	always #(HALF_PERIOD) clk = ~clk;

	task_execution_time_monitor_core #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	temon_stats_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.error_count  (error_count),
		.reports_due  (reports_due)
	);

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TIME_W-1:0] pick_period();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 65)
			return TIME_W'($urandom_range(1, 500));
		if (r < 90)
			return TIME_W'($urandom);
		return ALL_ONES;
	endfunction

	// Elapsed times cluster round the deadline so that misses and near misses both occur.
	function automatic logic [TIME_W-1:0] pick_delta(logic [TIME_W-1:0] period);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return period;
			2: return period + TIME_W'(1);
			3: return TIME_W'($urandom_range(0, 1000));
			4: return period - TIME_W'($urandom_range(1, 20));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		if (registered != 0 && $urandom_range(0, 99) < 85)
			return SLOT_W'($urandom_range(0, registered - 1));
		return SLOT_W'($urandom);
	endfunction

	// Offers one beat and returns at the edge that accepts it, after any idle gap.
	task automatic offer_event(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
			logic [TIME_W-1:0] now, logic [TIME_W-1:0] period);
		int unsigned gap;
		if (op == OP_REGISTER && registered < SLOTS) begin
			task_period[registered] = period;
			begun_at[registered]    = '0;
			registered++;
		end else if (op == OP_BEGIN && slot < registered) begin
			begun_at[slot] = now;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({period, now, slot});
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		beats_sent++;
		// Every fourth run of forty beats goes back to back.
		gap = ((beats_sent / 40) % 4 == 3) ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_item(output bit effective);
		int unsigned       r;
		logic [SLOT_W-1:0] slot;
		r         = $urandom_range(0, 99);
		slot      = pick_slot();
		effective = 1'b1;
		if (r < 4) begin
			offer_event(OP_REGISTER, SLOT_W'($urandom), $urandom, pick_period());
		end else if (r < 36) begin
			effective = slot < registered;
			offer_event(OP_BEGIN, slot, $urandom, $urandom);
		end else if (r < 68) begin
			effective = slot < registered;
			offer_event(OP_END, slot, begun_at[slot] + pick_delta(task_period[slot]), $urandom);
		end else if (r < 86) begin
			offer_event(OP_READ, slot, $urandom, $urandom);
		end else if (r < 90) begin
			offer_event(OP_RESET_ALL, SLOT_W'($urandom), $urandom, $urandom);
		end else if (r < 94) begin
			effective = 1'b0;
			offer_event(OP_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE)),
				SLOT_W'($urandom), $urandom, $urandom);
		end else begin
			// Broken pairs: stray begins and ends on any slot at arbitrary times.
			slot      = SLOT_W'($urandom);
			effective = slot < registered;
			offer_event(r[0] ? OP_BEGIN : OP_END, slot, $urandom, $urandom);
		end
	endtask

	// Receiver: random ready pattern with one long hold-off once the input is busy.
	initial begin
		int unsigned stall_left;
		int unsigned run_left;
		bit          held;
		stall_left = 0;
		run_left   = 0;
		held       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && beats_sent >= HOLD_OFF_AT) begin
				held       = 1'b1;
				stall_left = HOLD_OFF_CYCLES;
				run_left   = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (run_left != 0) begin
				run_left--;
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
				run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
					: $urandom_range(0, 8);
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		bit                effective;
		int unsigned       counted;
		logic [TIME_W-1:0] near_wrap;
		near_wrap = ALL_ONES - TIME_W'(10);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: reads fail, begin and end are ignored, as are the spare codes.
		offer_event(OP_READ, 4'hF, ALL_ONES, ALL_ONES);
		offer_event(OP_BEGIN, 4'h0, ALL_ONES, ALL_ONES);
		offer_event(OP_END, 4'h0, ALL_ONES, ALL_ONES);
		offer_event(OP_RESET_ALL, 4'h0, '0, '0);
		offer_event(OP_FIRST_SPARE, 4'hF, ALL_ONES, ALL_ONES);
		offer_event(OP_W'(OP_FIRST_SPARE + 1'b1), 4'h0, '0, '0);
		offer_event(OP_LAST_SPARE, 4'hF, ALL_ONES, ALL_ONES);
		// Slots 0 to 2: no deadline, the widest deadline and a deadline of 100 us.
		offer_event(OP_REGISTER, 4'hF, ALL_ONES, '0);
		offer_event(OP_REGISTER, 4'h0, '0, ALL_ONES);
		offer_event(OP_REGISTER, 4'h5, '0, TIME_W'(100));
		offer_event(OP_READ, 4'h0, '0, '0);
		// An end with no begin measures from the zero stamp written at registration.
		offer_event(OP_END, 4'h2, TIME_W'(50), '0);
		// Exactly on the deadline across the wrap, then one microsecond over it.
		offer_event(OP_BEGIN, 4'h2, near_wrap, '0);
		offer_event(OP_END, 4'h2, near_wrap + TIME_W'(100), '0);
		offer_event(OP_BEGIN, 4'h2, TIME_W'(1000), '0);
		offer_event(OP_END, 4'h2, TIME_W'(1101), '0);
		offer_event(OP_BEGIN, 4'h0, '0, ALL_ONES);
		offer_event(OP_END, 4'h0, ALL_ONES, ALL_ONES);
		offer_event(OP_BEGIN, 4'h1, TIME_W'(5), '0);
		offer_event(OP_END, 4'h1, TIME_W'(5), '0);
		offer_event(OP_READ, 4'h0, '0, '0);
		offer_event(OP_READ, 4'h1, '0, '0);
		offer_event(OP_READ, 4'h2, '0, '0);
		offer_event(OP_READ, 4'h3, '0, '0);
		offer_event(OP_RESET_ALL, 4'hA, ALL_ONES, ALL_ONES);
		offer_event(OP_READ, 4'h2, '0, '0);
		offer_event(OP_BEGIN, 4'h9, TIME_W'(7), '0);
		offer_event(OP_END, 4'h9, TIME_W'(9), '0);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			random_item(effective);
			if (effective)
				counted++;
		end

		// Fill whatever is left of the table, then register into a full one.
		while (registered < SLOTS)
			offer_event(OP_REGISTER, SLOT_W'($urandom), $urandom, pick_period());
		offer_event(OP_REGISTER, 4'hF, ALL_ONES, ALL_ONES);
		offer_event(OP_REGISTER, 4'h0, '0, TIME_W'(1));
		offer_event(OP_READ, 4'hF, '0, '0);
		s_axis_tvalid <= 1'b0;

		do
			@(posedge clk);
		while (reports_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule : tb_task_execution_time_monitor_core
